// ===== hw/rtl/csel_pkg.sv =====
// Shared types and constants for the kinematic cut and top-n selector.
// No dependencies; imported by every module of the block.
package csel_pkg;

    localparam int MAX_ITEMS = 32;
    localparam int EMIT_CAP  = 32;
    localparam int POS_W     = $clog2(MAX_ITEMS + 1);
    localparam int PT_W      = 20;
    localparam int ETA_W     = 16;
    localparam int IDX_W     = 5;
    localparam int CNT_W     = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 20;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_PT      = 3'd0,
        REG_MAX_ABS_ETA = 3'd1,
        REG_MIN_AMOUNT  = 3'd2,
        REG_TRUNCATE_AT = 3'd3,
        REG_SORT_BY_PT  = 3'd4
    } t_reg_idx;

    typedef enum logic [1:0] {
        KIND_FLAG  = 2'd0,
        KIND_COUNT = 2'd1,
        KIND_KEPT  = 2'd2
    } t_kind;

    typedef struct packed {
        logic [PT_W-1:0]         pt;
        logic signed [ETA_W-1:0] eta;
        logic                    last_in_event;
    } t_in_word;

    typedef struct packed {
        logic [1:0]              kind;
        logic [IDX_W-1:0]        index;
        logic                    selected;
        logic [PT_W-1:0]         out_pt;
        logic signed [ETA_W-1:0] out_eta;
        logic [CNT_W-1:0]        count;
        logic                    overflow;
        logic                    last_result;
    } t_out_word;

    typedef struct packed {
        logic                    valid;
        logic [PT_W-1:0]         pt;
        logic signed [ETA_W-1:0] eta;
        logic [IDX_W-1:0]        idx;
    } t_entry;

    typedef struct packed {
        logic ins;
        logic shift;
        logic flush;
        logic sort;
    } t_cell_ctl;

    function automatic logic [IDX_W-1:0] pos_to_idx(input logic [POS_W-1:0] pos);
        logic [31:0] wide;
        wide = 32'(pos);
        return wide[IDX_W-1:0];
    endfunction

endpackage

// ===== hw/rtl/csel_cell.sv =====
// One slot of the sorted insertion chain: holds a candidate, inserts or shifts.
// Depends on csel_pkg.
module csel_cell
    import csel_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    input  t_entry    i_left,
    input  logic      i_left_beat,
    input  t_entry    i_right,
    output t_entry    o_ent,
    output logic      o_beat
);

    t_entry r_ent;
    t_entry n_ent;

    // new word belongs at or above this slot
    assign o_beat = !r_ent.valid || (i_ctl.sort && (r_ent.pt < i_new.pt));
    assign o_ent  = r_ent;

    always_comb begin
        n_ent = r_ent;
        if (i_ctl.flush) begin
            n_ent.valid = 1'b0;
        end else if (i_ctl.ins && o_beat) begin
            n_ent = i_left_beat ? i_left : i_new;
        end else if (i_ctl.shift) begin
            n_ent = i_right;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent.valid <= 1'b0;
        end else begin
            r_ent.valid <= n_ent.valid;
        end
        r_ent.pt  <= n_ent.pt;
        r_ent.eta <= n_ent.eta;
        r_ent.idx <= n_ent.idx;
    end

endmodule

// ===== hw/rtl/csel_chain.sv =====
// Row of MAX_ITEMS insertion cells; head of the row drains toward the output.
// Depends on csel_pkg and csel_cell.
module csel_chain
    import csel_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  t_entry    i_new,
    output t_entry    o_head
);

    t_entry               w_ent [MAX_ITEMS];
    logic [MAX_ITEMS-1:0] w_beat;
    t_entry               w_empty;

    assign w_empty = '0;
    assign o_head  = w_ent[0];

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        t_entry w_left;
        t_entry w_right;
        logic   w_left_beat;

        if (g == 0) begin : g_first
            assign w_left      = w_empty;
            assign w_left_beat = 1'b0;
        end else begin : g_mid
            assign w_left      = w_ent[g-1];
            assign w_left_beat = w_beat[g-1];
        end

        if (g == MAX_ITEMS - 1) begin : g_last
            assign w_right = w_empty;
        end else begin : g_inner
            assign w_right = w_ent[g+1];
        end

        csel_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_ctl       (i_ctl),
            .i_new       (i_new),
            .i_left      (w_left),
            .i_left_beat (w_left_beat),
            .i_right     (w_right),
            .o_ent       (w_ent[g]),
            .o_beat      (w_beat[g])
        );
    end

endmodule

// ===== hw/rtl/cut_select_top_n_by_pt.sv =====
// Top level of the kinematic cut and top-n selector: config, control, output.
// Depends on csel_pkg and csel_chain.
//
//  port group   | dir | handshake                  | word
//  -------------+-----+----------------------------+-----------
//  candidate    | in  | i_start && !o_busy         | t_in_word
//  result       | out | o_res_valid strobe, 1 cycle| t_out_word
//  config write | in  | i_cfg_valid && o_cfg_ready | index, data
//
// A candidate is accepted whenever o_busy is low; its flag word appears the cycle after.
// An event's last candidate then holds o_busy high while ST_CNT forms the count
// word and ST_DRAIN shifts each kept word out of the chain.
// Synchronous active-low reset empties the chain and restores register defaults.
// Results cannot be stalled; o_cfg_ready is always high.
module cut_select_top_n_by_pt
    import csel_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    output logic                 o_busy,
    input  t_in_word             i_in,
    output logic                 o_res_valid,
    output t_out_word            o_res,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_DAT_W-1:0] i_cfg_data
);

    typedef enum logic [2:0] {
        ST_RUN   = 3'b001,
        ST_CNT   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [PT_W-1:0]   r_min_pt;
    logic [14:0]       r_max_eta;
    logic [CNT_W-1:0]  r_min_amt;
    logic [6:0]        r_trunc;
    logic              r_sort;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_cnt, n_cnt;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_res_v, n_res_v;
    t_out_word         r_res, n_res;

    logic              w_accept;
    logic              w_ovf;
    logic              w_pass;
    logic [ETA_W:0]    w_eta_x;
    logic [ETA_W:0]    w_aeta;
    logic [6:0]        w_cnt7;
    logic [6:0]        w_keep7;
    logic [CNT_W-1:0]  w_keep;
    t_cell_ctl         w_ctl;
    t_entry            w_new;
    t_entry            w_head;

    assign o_busy      = (r_state != ST_RUN);
    assign o_cfg_ready = 1'b1;
    assign o_res_valid = r_res_v;
    assign o_res       = r_res;

    assign w_accept = i_start && !o_busy;
    assign w_ovf    = (r_pos == POS_W'(MAX_ITEMS));
    assign w_eta_x  = {i_in.eta[ETA_W-1], i_in.eta};
    assign w_aeta   = i_in.eta[ETA_W-1] ? (~w_eta_x + 1'b1) : w_eta_x;
    assign w_pass   = !w_ovf && (i_in.pt >= r_min_pt)
                      && (w_aeta <= {2'b00, r_max_eta});

    always_comb begin
        w_cnt7  = 7'(r_cnt);
        w_keep7 = (w_cnt7 < 7'(r_min_amt)) ? 7'd0 : w_cnt7;
        if (r_sort && !r_trunc[6] && (r_trunc < w_keep7)) begin
            w_keep7 = r_trunc;
        end
        if (w_keep7 > 7'(EMIT_CAP)) begin
            w_keep7 = 7'(EMIT_CAP);
        end
        w_keep = w_keep7[CNT_W-1:0];
    end

    assign w_new.valid = 1'b1;
    assign w_new.pt    = i_in.pt;
    assign w_new.eta   = i_in.eta;
    assign w_new.idx   = pos_to_idx(r_pos);

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_cnt   = r_cnt;
        n_left  = r_left;
        n_res_v = 1'b0;
        n_res   = r_res;
        w_ctl   = '0;
        w_ctl.sort = r_sort;
        case (r_state)
            ST_RUN: begin
                if (w_accept) begin
                    w_ctl.ins           = w_pass;
                    n_res_v             = 1'b1;
                    n_res               = '0;
                    n_res.kind          = KIND_FLAG;
                    n_res.index         = pos_to_idx(r_pos);
                    n_res.selected      = w_pass;
                    n_res.overflow      = w_ovf;
                    if (!w_ovf) begin
                        n_pos = r_pos + 1'b1;
                    end
                    if (w_pass) begin
                        n_cnt = r_cnt + 1'b1;
                    end
                    if (i_in.last_in_event) begin
                        n_state = ST_CNT;
                    end
                end
            end
            ST_CNT: begin
                n_res_v           = 1'b1;
                n_res             = '0;
                n_res.kind        = KIND_COUNT;
                n_res.count       = CNT_W'(r_cnt);
                n_res.last_result = (w_keep == '0);
                n_left            = w_keep;
                n_pos             = '0;
                n_cnt             = '0;
                if (w_keep == '0) begin
                    w_ctl.flush = 1'b1;
                    n_state     = ST_RUN;
                end else begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                w_ctl.shift       = 1'b1;
                n_res_v           = 1'b1;
                n_res             = '0;
                n_res.kind        = KIND_KEPT;
                n_res.index       = w_head.idx;
                n_res.selected    = 1'b1;
                n_res.out_pt      = w_head.pt;
                n_res.out_eta     = w_head.eta;
                n_res.last_result = (r_left == CNT_W'(1));
                n_left            = r_left - 1'b1;
                if (r_left == CNT_W'(1)) begin
                    w_ctl.flush = 1'b1;
                    n_state     = ST_RUN;
                end
            end
            default: begin
                n_state = ST_RUN;
            end
        endcase
    end

    csel_chain u_chain (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_new   (w_new),
        .o_head  (w_head)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_RUN;
            r_pos     <= '0;
            r_cnt     <= '0;
            r_left    <= '0;
            r_res_v   <= 1'b0;
            r_min_pt  <= '0;
            r_max_eta <= 15'h7FFF;
            r_min_amt <= '0;
            r_trunc   <= 7'h7F;
            r_sort    <= 1'b1;
        end else begin
            r_state <= n_state;
            r_pos   <= n_pos;
            r_cnt   <= n_cnt;
            r_left  <= n_left;
            r_res_v <= n_res_v;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_MIN_PT:      r_min_pt  <= i_cfg_data[PT_W-1:0];
                    REG_MAX_ABS_ETA: r_max_eta <= i_cfg_data[14:0];
                    REG_MIN_AMOUNT:  r_min_amt <= i_cfg_data[CNT_W-1:0];
                    REG_TRUNCATE_AT: r_trunc   <= i_cfg_data[6:0];
                    REG_SORT_BY_PT:  r_sort    <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
        end
        r_res <= n_res;
    end

    a_drain_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> r_left != '0)
        else $error("drain with nothing left");

    a_cnt_le_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= r_pos)
        else $error("pass count above position");

    a_last_to_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept && i_in.last_in_event |=> r_state == ST_CNT)
        else $error("last candidate did not start count");

    a_kept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DRAIN |-> w_head.valid)
        else $error("draining an empty slot");

endmodule
